// ===== sv/line_normal_form_from_points_defines.svh =====
// ----------------------------------------------------------------------------
// Line normal form: assertion macros
// Shared concurrent assertion forms for the line normal form block.
// ----------------------------------------------------------------------------
`ifndef LINE_NORMAL_FORM_FROM_POINTS_DEFINES_SVH
`define LINE_NORMAL_FORM_FROM_POINTS_DEFINES_SVH

// implication checked every cycle out of reset
`define LNF_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("line normal form check failed");

// fixed latency from request to strobe
`define LNF_ASSERT_LAT(label, ante, cons, lat) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##lat (cons)) \
        else $error("line normal form latency check failed");

`endif

// ===== sv/lnf_pkg.sv =====
// ----------------------------------------------------------------------------
// Line normal form package
// Types and fixed constants for the line normal form pipeline.
// ----------------------------------------------------------------------------
package lnf_pkg;

    localparam int COEF_AB_W  = 32;
    localparam int COEF_C_W   = 34;
    localparam int QAB_BITS   = 31;
    localparam int QC_BITS    = 34;
    localparam int FRAC_SHIFT = 60;

    localparam logic [QC_BITS-1:0] C_MAX_POS = 34'h1_FFFF_FFFF;
    localparam logic [QC_BITS-1:0] C_MAX_NEG = 34'h2_0000_0000;

    typedef struct packed {
        logic degen;
        logic branch1;
        logic dx_neg;
        logic dy_neg;
        logic m_neg;
    } ctl_t;

endpackage

// ===== sv/line_normal_form_from_points.sv =====
// Throughput: one request per cycle; busy is held low.
// The work is a 34-stage digit-recurrence root quotient, one quotient bit per
// stage, in three lanes (A, B, C) side by side, after five setup stages.
// Reset (rst_n, async, active low) clears all stage valid bits.
// ----------------------------------------------------------------------------
// Line normal form from two points
// Unit-normal line equation Ax+By+C=0 from two Q16.16 endpoints.
// ----------------------------------------------------------------------------
`include "line_normal_form_from_points_defines.svh"

module line_normal_form_from_points #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [COORD_WIDTH-1:0]       start_x,
    input  logic signed [COORD_WIDTH-1:0]       start_y,
    input  logic signed [COORD_WIDTH-1:0]       end_x,
    input  logic signed [COORD_WIDTH-1:0]       end_y,
    output logic                                done,
    output logic signed [lnf_pkg::COEF_AB_W-1:0] coef_a,
    output logic signed [lnf_pkg::COEF_AB_W-1:0] coef_b,
    output logic signed [lnf_pkg::COEF_C_W-1:0]  coef_c,
    output logic                                degenerate
);

    localparam int CW   = COORD_WIDTH;
    localparam int DW   = CW + 1;
    localparam int SW   = 2 * DW;
    localparam int PW   = 2 * CW;
    localparam int MW   = 2 * CW;
    localparam int LW   = 4 * CW + 72;
    localparam int QB   = lnf_pkg::QC_BITS;
    localparam int QAB  = lnf_pkg::QAB_BITS;
    localparam int NI   = QB;
    localparam int NSTG = NI + 6;

    logic [NSTG-1:0] vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[NSTG-2:0], start};
        end
    end

    assign busy = 1'b0;

    // stage 1: capture
    logic signed [CW-1:0] xs_reg, ys_reg, xe_reg, ye_reg;

    always_ff @(posedge clk)
    begin
        xs_reg <= start_x;
        ys_reg <= start_y;
        xe_reg <= end_x;
        ye_reg <= end_y;
    end

    // stage 2: differences and cross products
    logic signed [DW-1:0] dx_reg, dy_reg;
    logic signed [PW-1:0] p1_reg, p2_reg;

    always_ff @(posedge clk)
    begin
        dx_reg <= DW'(xs_reg) - DW'(xe_reg);
        dy_reg <= DW'(ys_reg) - DW'(ye_reg);
        p1_reg <= PW'(xs_reg) * PW'(ye_reg);
        p2_reg <= PW'(ys_reg) * PW'(xe_reg);
    end

    // stage 3: magnitudes and flags
    logic [DW-1:0]         adx_reg, ady_reg;
    logic [MW-1:0]         mmag_reg;
    lnf_pkg::ctl_t         ctl3_reg;
    logic signed [MW:0]    m_next;
    logic [DW-1:0]         adx_next, ady_next;

    always_comb
    begin
        m_next   = (MW+1)'(p1_reg) - (MW+1)'(p2_reg);
        adx_next = dx_reg[DW-1] ? DW'(-dx_reg) : DW'(dx_reg);
        ady_next = dy_reg[DW-1] ? DW'(-dy_reg) : DW'(dy_reg);
    end

    always_ff @(posedge clk)
    begin
        adx_reg          <= adx_next;
        ady_reg          <= ady_next;
        mmag_reg         <= m_next[MW] ? MW'(-m_next) : MW'(m_next);
        ctl3_reg.degen   <= (dx_reg == '0) && (dy_reg == '0);
        ctl3_reg.branch1 <= adx_next > ady_next;
        ctl3_reg.dx_neg  <= dx_reg[DW-1];
        ctl3_reg.dy_neg  <= dy_reg[DW-1];
        ctl3_reg.m_neg   <= m_next[MW];
    end

    // stage 4: squares, offset square in partial products
    logic [SW-1:0]   bx_reg, by_reg;
    logic [2*CW-1:0] mhh_reg, mhl_reg, mll_reg;
    lnf_pkg::ctl_t   ctl4_reg;

    always_ff @(posedge clk)
    begin
        bx_reg   <= SW'(adx_reg) * SW'(adx_reg);
        by_reg   <= SW'(ady_reg) * SW'(ady_reg);
        mhh_reg  <= (2*CW)'(mmag_reg[MW-1:CW]) * (2*CW)'(mmag_reg[MW-1:CW]);
        mhl_reg  <= (2*CW)'(mmag_reg[MW-1:CW]) * (2*CW)'(mmag_reg[CW-1:0]);
        mll_reg  <= (2*CW)'(mmag_reg[CW-1:0]) * (2*CW)'(mmag_reg[CW-1:0]);
        ctl4_reg <= ctl3_reg;
    end

    // root quotient pipeline: lane 0 = x, 1 = y, 2 = offset
    logic [LW-1:0]    r_reg [0:NI][0:2];
    logic [LW-1:0]    p_reg [0:NI][0:2];
    logic [QB-1:0]    q_reg [0:NI][0:2];
    logic [SW:0]      s_reg [0:NI];
    lnf_pkg::ctl_t    ctl_reg [0:NI];

    always_ff @(posedge clk)
    begin
        s_reg[0]    <= (SW+1)'(bx_reg) + (SW+1)'(by_reg);
        r_reg[0][0] <= LW'(bx_reg) << lnf_pkg::FRAC_SHIFT;
        r_reg[0][1] <= LW'(by_reg) << lnf_pkg::FRAC_SHIFT;
        r_reg[0][2] <= (LW'(mhh_reg) << (2*CW)) + (LW'(mhl_reg) << (CW+1)) + LW'(mll_reg);
        for (int l = 0; l < 3; l++)
        begin
            p_reg[0][l] <= '0;
            q_reg[0][l] <= '0;
        end
        ctl_reg[0]  <= ctl4_reg;
    end

    for (genvar j = 0; j < NI; j++)
    begin : g_iter
        localparam int K = QB - 1 - j;
        logic [LW-1:0] r_next [0:2];
        logic [LW-1:0] p_next [0:2];
        logic [QB-1:0] q_next [0:2];

        always_comb
        begin
            logic [LW-1:0] sx;
            logic [LW-1:0] delta;
            sx = LW'(s_reg[j]);
            for (int l = 0; l < 3; l++)
            begin
                delta     = (p_reg[j][l] << (K+1)) + (sx << (2*K));
                r_next[l] = r_reg[j][l];
                p_next[l] = p_reg[j][l];
                q_next[l] = q_reg[j][l];
                if (((l == 2) || (K < QAB)) && (delta <= r_reg[j][l]))
                begin
                    r_next[l]    = r_reg[j][l] - delta;
                    p_next[l]    = p_reg[j][l] + (sx << K);
                    q_next[l][K] = 1'b1;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            for (int l = 0; l < 3; l++)
            begin
                r_reg[j+1][l] <= r_next[l];
                p_reg[j+1][l] <= p_next[l];
                q_reg[j+1][l] <= q_next[l];
            end
            s_reg[j+1]   <= s_reg[j];
            ctl_reg[j+1] <= ctl_reg[j];
        end
    end

    // output stage: signs, saturation and degenerate zeroing
    logic signed [lnf_pkg::COEF_AB_W-1:0] qx_s, qy_s, a_next, b_next;
    logic signed [lnf_pkg::COEF_C_W-1:0]  c_next;
    logic [QB-1:0]                        qc;
    logic                                 neg_sgn, cneg;
    lnf_pkg::ctl_t                        cf;

    always_comb
    begin
        cf      = ctl_reg[NI];
        qx_s    = lnf_pkg::COEF_AB_W'(q_reg[NI][0]);
        qy_s    = lnf_pkg::COEF_AB_W'(q_reg[NI][1]);
        qc      = q_reg[NI][2];
        neg_sgn = cf.dx_neg != cf.dy_neg;
        if (cf.branch1)
        begin
            a_next = neg_sgn ? -qy_s : qy_s;
            b_next = -qx_s;
            cneg   = cf.dx_neg != cf.m_neg;
        end
        else
        begin
            a_next = -qy_s;
            b_next = neg_sgn ? -qx_s : qx_s;
            cneg   = (!cf.dy_neg) != cf.m_neg;
        end
        if (cneg)
        begin
            c_next = -$signed((qc > lnf_pkg::C_MAX_NEG) ? lnf_pkg::C_MAX_NEG : qc);
        end
        else
        begin
            c_next = $signed((qc > lnf_pkg::C_MAX_POS) ? lnf_pkg::C_MAX_POS : qc);
        end
        if (cf.degen)
        begin
            a_next = '0;
            b_next = '0;
            c_next = '0;
        end
    end

    logic signed [lnf_pkg::COEF_AB_W-1:0] a_reg, b_reg;
    logic signed [lnf_pkg::COEF_C_W-1:0]  c_reg;
    logic                                 dg_reg;

    always_ff @(posedge clk)
    begin
        a_reg  <= a_next;
        b_reg  <= b_next;
        c_reg  <= c_next;
        dg_reg <= cf.degen;
    end

    assign done       = vld_reg[NSTG-1];
    assign coef_a     = a_reg;
    assign coef_b     = b_reg;
    assign coef_c     = c_reg;
    assign degenerate = dg_reg;

    `LNF_ASSERT_LAT(a_latency, start, done, NSTG)
    `LNF_ASSERT_IMP(a_degen_zero, done && degenerate, {coef_a, coef_b, coef_c} == '0)
    `LNF_ASSERT_IMP(a_unit_normal, done && !degenerate, (coef_a != '0) || (coef_b != '0))
    `LNF_ASSERT_IMP(a_never_busy, 1'b1, !busy)

endmodule

// ===== bench/line_normal_form_from_points_test.sv =====
// ----------------------------------------------------------------------------
// Line normal form from two points: testbench
// Sends endpoint pairs and checks each strobed result, field by field, against
// an exact integer predictor of the unit-normal line coefficients.
// ----------------------------------------------------------------------------
typedef struct {
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic signed [33:0] c;
    logic               degen;
} line_coef_t;

class line_coef_board;
    line_coef_t pending[$];
    int         fails;

    function new();
        fails = 0;
    endfunction

    // largest q < 2^nbits with q*q*sq <= target
    static function automatic logic [63:0] root_trunc(logic [255:0] target,
                                                      logic [255:0] sq, int nbits);
        logic [63:0]  q;
        logic [63:0]  cand;
        logic [255:0] prod;
        q = '0;
        for (int bit_i = nbits - 1; bit_i >= 0; bit_i--)
        begin
            cand = q | (64'd1 << bit_i);
            prod = 256'(cand) * 256'(cand) * sq;
            if (prod <= target)
                q = cand;
        end
        return q;
    endfunction

    static function automatic line_coef_t normal_form(logic signed [31:0] xs,
                                                      logic signed [31:0] ys,
                                                      logic signed [31:0] xe,
                                                      logic signed [31:0] ye);
        line_coef_t         r;
        logic signed [63:0] dx, dy;
        logic [63:0]        adx, ady, qx, qy, qc;
        logic [255:0]       bx, by, sum, mm;
        logic signed [127:0] m;
        logic [127:0]       am;
        logic               branch1, flip, cneg;
        dx = 64'(xs) - 64'(xe);
        dy = 64'(ys) - 64'(ye);
        r = '{a: '0, b: '0, c: '0, degen: 1'b0};
        if (dx == 0 && dy == 0)
        begin
            r.degen = 1'b1;
            return r;
        end
        adx = dx < 0 ? -dx : dx;
        ady = dy < 0 ? -dy : dy;
        bx = 256'(adx) * 256'(adx);
        by = 256'(ady) * 256'(ady);
        sum = bx + by;
        qx = root_trunc(bx << 60, sum, 31);
        qy = root_trunc(by << 60, sum, 31);
        branch1 = adx > ady;
        flip = (dx < 0) != (dy < 0);
        if (branch1)
        begin
            r.a = flip ? -32'(qy) : 32'(qy);
            r.b = -32'(qx);
        end
        else
        begin
            r.a = -32'(qy);
            r.b = flip ? -32'(qx) : 32'(qx);
        end
        m = 128'(xs) * 128'(ye) - 128'(ys) * 128'(xe);
        am = m < 0 ? -m : m;
        mm = 256'(am) * 256'(am);
        qc = root_trunc(mm, sum, 34);
        cneg = branch1 ? ((dx < 0) != (m < 0)) : ((dy > 0) != (m < 0));
        if (cneg)
        begin
            if (qc > 64'd8589934592)
                qc = 64'd8589934592;
            r.c = -34'(qc);
        end
        else
        begin
            if (qc > 64'd8589934591)
                qc = 64'd8589934591;
            r.c = 34'(qc);
        end
        return r;
    endfunction

    function void note_request(logic signed [31:0] xs, logic signed [31:0] ys,
                               logic signed [31:0] xe, logic signed [31:0] ye);
        pending.push_back(normal_form(xs, ys, xe, ye));
    endfunction

    function void check_result(line_coef_t got);
        line_coef_t want;
        if (pending.size() == 0)
        begin
            $display("%0t: unexpected result a=%0d b=%0d c=%0d degen=%0b",
                     $realtime, got.a, got.b, got.c, got.degen);
            fails++;
            return;
        end
        want = pending.pop_front();
        if (got.a !== want.a)
        begin
            $display("%0t: coef_a expected %0d actual %0d", $realtime, want.a, got.a);
            fails++;
        end
        if (got.b !== want.b)
        begin
            $display("%0t: coef_b expected %0d actual %0d", $realtime, want.b, got.b);
            fails++;
        end
        if (got.c !== want.c)
        begin
            $display("%0t: coef_c expected %0d actual %0d", $realtime, want.c, got.c);
            fails++;
        end
        if (got.degen !== want.degen)
        begin
            $display("%0t: degenerate expected %0b actual %0b",
                     $realtime, want.degen, got.degen);
            fails++;
        end
    endfunction
endclass

module line_normal_form_from_points_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  LIMIT = 2000000;
    localparam logic signed [31:0] PMAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] PMIN = 32'sh8000_0000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [31:0] start_x = '0, start_y = '0, end_x = '0, end_y = '0;
    logic done;
    logic signed [31:0] coef_a, coef_b;
    logic signed [33:0] coef_c;
    logic degenerate;

    line_coef_board board = new();
    int idle_pct = 0;
    int cycles = 0;

    line_normal_form_from_points #(.COORD_WIDTH(32)) dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .start_x(start_x), .start_y(start_y), .end_x(end_x), .end_y(end_y),
        .done(done), .coef_a(coef_a), .coef_b(coef_b), .coef_c(coef_c),
        .degenerate(degenerate)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
        if (rst_n)
        begin
            if (start && !busy)
                board.note_request(start_x, start_y, end_x, end_y);
            if (done)
                board.check_result('{a: coef_a, b: coef_b, c: coef_c, degen: degenerate});
        end
    end

    task automatic send_request(logic signed [31:0] xs, logic signed [31:0] ys,
                                logic signed [31:0] xe, logic signed [31:0] ye);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        start_x <= xs;
        start_y <= ys;
        end_x <= xe;
        end_y <= ye;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_random();
        logic signed [31:0] xs, ys, xe, ye;
        int kind;
        xs = $urandom;
        ys = $urandom;
        xe = $urandom;
        ye = $urandom;
        kind = $urandom_range(9);
        case (kind)
            0, 1:
            begin
                xe = xs + $signed($urandom_range(2000)) - 1000;
                ye = ys + $signed($urandom_range(2000)) - 1000;
            end
            2:
            begin
                xe = xs;
                ye = ys;
            end
            3: xe = xs;
            4: ye = ys;
            5:
            begin
                xe = xs + $signed($urandom_range(65536));
                ye = $urandom_range(1) ? ys + (xe - xs) : ys - (xe - xs);
            end
            6:
            begin
                xs = $signed($urandom_range(1 << 20)) - (1 << 19);
                ys = $signed($urandom_range(1 << 20)) - (1 << 19);
                xe = $signed($urandom_range(1 << 20)) - (1 << 19);
                ye = $signed($urandom_range(1 << 20)) - (1 << 19);
            end
            default: ;
        endcase
        send_request(xs, ys, xe, ye);
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(0, 0, 0, 0);
        send_request(PMAX, PMIN, PMAX, PMIN);
        send_request(PMAX, PMAX, PMIN, PMIN);
        send_request(PMIN, PMIN, PMAX, PMAX);
        send_request(PMIN, PMAX, PMAX, PMIN);
        send_request(PMAX, PMIN, PMIN, PMAX);
        send_request(PMIN, 0, PMAX, 0);
        send_request(PMAX, 5, PMIN, 5);
        send_request(0, PMIN, 0, PMAX);
        send_request(-7, PMAX, -7, PMIN);
        send_request(32'sh10000, 0, 0, 0);
        send_request(0, 0, 0, 32'sh10000);
        send_request(3, 3, 1, 1);
        send_request(1, 3, 3, 1);
        send_request(-1, -1, 1, 1);
        send_request(1, 0, 0, 0);
        send_request(0, 1, 0, 0);
        send_request(0, 0, 1, 0);
        send_request(0, 0, 0, -1);
        send_request(100, -50, -300, 20);
        send_request(-100, 50, 300, -20);
        send_request(PMAX, 0, 0, PMAX);
        send_request(PMIN, 1, 1, PMIN);
        drain();

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: idle_pct = 0;
                1: idle_pct = 51;
                2: idle_pct = 0;
                default: idle_pct = 6;
            endcase
            for (int i = 0; i < 345; i++)
                send_random();
            if (phase == 1)
                drain();
        end
        drain();
        repeat (60) @(posedge clk);
        if (board.fails == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+sv
sv/lnf_pkg.sv
sv/line_normal_form_from_points.sv
bench/line_normal_form_from_points_test.sv
